/* rtl/sprc_pkg.sv */
// Shared types and constants for the row-group prune and range coalescer.
package sprc_pkg;

    localparam int POS_W      = 40;
    localparam int OFF_W      = 48;
    localparam int LEN_W      = 32;
    localparam int BKT_W      = 6;
    localparam int BITS_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int BUCKETS_DEF = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW       = 3'd0,
        CFG_RANGE_HIGH      = 3'd1,
        CFG_PARENT_VALID    = 3'd2,
        CFG_PARENT_POSITION = 3'd3,
        CFG_LOW_BUCKET      = 3'd4,
        CFG_HIGH_BUCKET     = 3'd5,
        CFG_PARENT_BUCKET   = 3'd6,
        CFG_SPLIT_TARGET    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic              unknown_sketch;
        logic [POS_W-1:0]  pos_min;
        logic [POS_W-1:0]  pos_max;
        logic [BITS_W-1:0] bucket_bits;
        logic [OFF_W-1:0]  data_offset;
        logic [LEN_W-1:0]  data_len;
        logic              end_of_shard;
    } t_in_item;

    typedef struct packed {
        logic             interval_hit;
        logic             bitmap_hit;
        logic             kept;
        logic             chunk_valid;
        logic [OFF_W-1:0] chunk_start;
        logic [OFF_W-1:0] chunk_end;
        logic             last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] range_low;
        logic [POS_W-1:0] range_high;
        logic             parent_valid;
        logic [POS_W-1:0] parent_position;
        logic [BKT_W-1:0] low_bucket;
        logic [BKT_W-1:0] high_bucket;
        logic [BKT_W-1:0] parent_bucket;
        logic [OFF_W-1:0] cut_len;
    } t_cfg;

    // register values after reset
    localparam t_cfg CFG_RESET = '{
        range_low:       '0,
        range_high:      '0,
        parent_valid:    1'b0,
        parent_position: '0,
        low_bucket:      '0,
        high_bucket:     '0,
        parent_bucket:   '0,
        cut_len:         OFF_W'(1)
    };

    // filter verdict and byte range of one group
    typedef struct packed {
        logic             iv;
        logic             bm;
        logic             kp;
        logic             eos;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] end_sat;
    } t_grp;

endpackage

/* rtl/sprc_filter.sv */
// Input register, interval and bucket bitmap tests, and verdict register.
module sprc_filter #(
    parameter int BUCKETS = sprc_pkg::BUCKETS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sprc_pkg::t_in_item i_item,
    output logic               o_ready,
    input  sprc_pkg::t_cfg     i_cfg,
    input  logic               i_b_ready,
    output logic               o_b_valid,
    output sprc_pkg::t_grp     o_grp
);
    import sprc_pkg::*;

    logic     r_a_valid, n_a_valid;
    t_in_item r_a_item;
    logic     r_b_valid, n_b_valid;
    t_grp     r_b_grp, n_b_grp;

    logic              a_adv;
    logic              nonempty, grp_ok;
    logic              iv_range, iv_par, bm_range, bm_par;
    logic [BITS_W-1:0] mask;
    logic [OFF_W:0]    end_sum;

    assign o_ready   = !r_a_valid || i_b_ready;
    assign a_adv     = r_a_valid && i_b_ready;
    assign o_b_valid = r_b_valid;
    assign o_grp     = r_b_grp;

    always_comb begin
        for (int i = 0; i < BITS_W; i++) begin
            mask[i] = (BKT_W'(i) >= i_cfg.low_bucket) && (BKT_W'(i) <= i_cfg.high_bucket)
                      && (i < BUCKETS);
        end
    end

    assign nonempty = i_cfg.range_low < i_cfg.range_high;
    assign grp_ok   = r_a_item.pos_min <= r_a_item.pos_max;
    assign iv_range = nonempty && (r_a_item.pos_max >= i_cfg.range_low)
                      && (r_a_item.pos_min < i_cfg.range_high);
    assign iv_par   = i_cfg.parent_valid && (i_cfg.parent_position >= r_a_item.pos_min)
                      && (i_cfg.parent_position <= r_a_item.pos_max);
    assign bm_range = nonempty && |(r_a_item.bucket_bits & mask);
    assign bm_par   = i_cfg.parent_valid && r_a_item.bucket_bits[i_cfg.parent_bucket]
                      && ({1'b0, i_cfg.parent_bucket} < (BKT_W+1)'(BUCKETS));
    assign end_sum  = {1'b0, r_a_item.data_offset} + (OFF_W+1)'(r_a_item.data_len);

    always_comb begin
        n_b_grp.iv      = r_a_item.unknown_sketch || (grp_ok && (iv_range || iv_par));
        n_b_grp.bm      = r_a_item.unknown_sketch || (grp_ok && (bm_range || bm_par));
        n_b_grp.kp      = n_b_grp.iv && n_b_grp.bm;
        n_b_grp.eos     = r_a_item.end_of_shard;
        n_b_grp.off     = r_a_item.data_offset;
        n_b_grp.len     = r_a_item.data_len;
        n_b_grp.end_sat = end_sum[OFF_W] ? {OFF_W{1'b1}} : end_sum[OFF_W-1:0];
        n_a_valid = o_ready ? i_valid : r_a_valid;
        n_b_valid = i_b_ready ? r_a_valid : r_b_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_item <= i_item;
        end
        if (a_adv) begin
            r_b_grp <= n_b_grp;
        end
    end

endmodule

/* rtl/sprc_coalesce.sv */
// Open byte range state; merges kept groups and emits closed ranges.
module sprc_coalesce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  sprc_pkg::t_grp                i_grp,
    input  logic [sprc_pkg::OFF_W-1:0]    i_split,
    output logic                          o_two,
    output sprc_pkg::t_out_item           o_res0,
    output sprc_pkg::t_out_item           o_res1
);
    import sprc_pkg::*;

    logic [OFF_W-1:0] r_start, r_end, n_start, n_end;

    logic             open, cont, emit_prior, emit_new, nopen, cut;
    logic [OFF_W:0]   ext_sum;
    logic [OFF_W-1:0] ext, ns, ne, span;

    assign open    = r_end > r_start;
    assign cont    = open && (r_end == i_grp.off);
    assign ext_sum = {1'b0, r_end} + (OFF_W+1)'(i_grp.len);
    assign ext     = ext_sum[OFF_W] ? {OFF_W{1'b1}} : ext_sum[OFF_W-1:0];
    assign ns      = cont ? r_start : i_grp.off;
    assign ne      = cont ? ext : i_grp.end_sat;
    assign nopen   = ne > ns;
    assign span    = ne - ns;
    assign cut     = nopen && (span >= i_split);

    assign emit_prior = i_grp.kp ? (open && !cont) : open;
    assign emit_new   = i_grp.kp && nopen && (cut || i_grp.eos);
    assign o_two      = emit_prior && emit_new;

    always_comb begin
        o_res0 = '0;
        o_res0.interval_hit = i_grp.iv;
        o_res0.bitmap_hit   = i_grp.bm;
        o_res0.kept         = i_grp.kp;
        o_res1 = o_res0;
        o_res0.last_of_run  = !o_two;
        o_res1.last_of_run  = 1'b1;
        if (emit_prior) begin
            o_res0.chunk_valid = 1'b1;
            o_res0.chunk_start = r_start;
            o_res0.chunk_end   = r_end;
        end else if (emit_new) begin
            o_res0.chunk_valid = 1'b1;
            o_res0.chunk_start = ns;
            o_res0.chunk_end   = ne;
        end
        o_res1.chunk_valid = 1'b1;
        o_res1.chunk_start = ns;
        o_res1.chunk_end   = ne;

        if (!i_grp.kp || cut || i_grp.eos) begin
            n_start = '0;
            n_end   = '0;
        end else begin
            n_start = ns;
            n_end   = ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_fire) begin
            r_start <= n_start;
            r_end   <= n_end;
        end
    end

endmodule

/* rtl/sprc_out_fifo.sv */
// Four-entry result queue: one or two pushes, one pop per cycle while the output is not stalled.
module sprc_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_two,
    input  sprc_pkg::t_out_item i_res0,
    input  sprc_pkg::t_out_item i_res1,
    output logic                o_room,
    output logic                o_valid,
    output sprc_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import sprc_pkg::*;

    t_out_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               pop;
    logic [FIFO_CW-1:0] push_n;
    logic [FIFO_AW-1:0] wptr1;

    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];
    assign o_room  = r_count < FIFO_CW'(FIFO_DEPTH - 1);
    assign pop     = o_valid && !i_stall;
    assign wptr1   = r_wptr + FIFO_AW'(1);

    always_comb begin
        push_n  = !i_push ? '0 : (i_two ? FIFO_CW'(2) : FIFO_CW'(1));
        n_count = r_count + push_n - FIFO_CW'(pop);
        n_wptr  = r_wptr + push_n[FIFO_AW-1:0];
        n_rptr  = r_rptr + FIFO_AW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wptr  <= '0;
            r_rptr  <= '0;
        end else begin
            r_count <= n_count;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res0;
            if (i_two) begin
                r_mem[wptr1] <= i_res1;
            end
        end
    end

endmodule

/* rtl/sprc_cfg_regs.sv */
// Configuration register file.
module sprc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sprc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sprc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sprc_pkg::t_cfg                    o_cfg
);
    import sprc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RANGE_LOW:       r_cfg.range_low       <= i_cfg_data[POS_W-1:0];
                CFG_RANGE_HIGH:      r_cfg.range_high      <= i_cfg_data[POS_W-1:0];
                CFG_PARENT_VALID:    r_cfg.parent_valid    <= i_cfg_data[0];
                CFG_PARENT_POSITION: r_cfg.parent_position <= i_cfg_data[POS_W-1:0];
                CFG_LOW_BUCKET:      r_cfg.low_bucket      <= i_cfg_data[BKT_W-1:0];
                CFG_HIGH_BUCKET:     r_cfg.high_bucket     <= i_cfg_data[BKT_W-1:0];
                CFG_PARENT_BUCKET:   r_cfg.parent_bucket   <= i_cfg_data[BKT_W-1:0];
                CFG_SPLIT_TARGET:    r_cfg.cut_len         <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/sketch_prune_range_coalescer_core.sv */
// Top level: row-group prune filter and byte-range coalescer.
// An accepted item passes the input register, the verdict register and the result queue before its first result shows.
// Throughput: one item per cycle while the queue has room and the output is not stalled; an item
// that closes two ranges gives two results, popped one at a time by the single-pop result queue.
// Reset (synchronous, active low) clears pipeline valids, the result queue,
// the open range and the configuration registers (cut length to 1).
module sketch_prune_range_coalescer_core #(
    parameter int BUCKETS = sprc_pkg::BUCKETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  sprc_pkg::t_in_item               i_item,
    output logic                             o_stall,
    output logic                             o_valid,
    output sprc_pkg::t_out_item              o_item,
    input  logic                             i_stall,
    input  logic                             i_cfg_we,
    input  logic [sprc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sprc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sprc_pkg::*;

    t_cfg      cfg;
    t_grp      grp;
    t_out_item res0, res1;
    logic      in_ready, b_valid, b_ready, fire, room, two;

    assign o_stall = !in_ready;
    assign b_ready = !b_valid || room;
    assign fire    = b_valid && room;

    sprc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sprc_filter #(
        .BUCKETS (BUCKETS)
    ) u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (i_item),
        .o_ready   (in_ready),
        .i_cfg     (cfg),
        .i_b_ready (b_ready),
        .o_b_valid (b_valid),
        .o_grp     (grp)
    );

    sprc_coalesce u_coal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_grp   (grp),
        .i_split (cfg.cut_len),
        .o_two   (two),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    sprc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_two   (two),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    // a pruned group closes at most one range
    a_prune_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.kept) |-> o_item.last_of_run)
        else $error("pruned group gave more than one result");

    // closed ranges are never empty
    a_chunk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.chunk_valid) |-> (o_item.chunk_end > o_item.chunk_start))
        else $error("empty range reported");

    // an item with no closed range gives one result with a zeroed range
    a_no_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.chunk_valid) |->
        (o_item.last_of_run && o_item.chunk_start == '0 && o_item.chunk_end == '0))
        else $error("malformed empty result");

    // kept implies both tests hit
    a_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kept) |-> (o_item.interval_hit && o_item.bitmap_hit))
        else $error("kept without both hits");

endmodule
